[rtl/bwh_pkg.sv]
package bwh_pkg;

  localparam int OUT_WIDTH   = 20;
  localparam int ROOT_BITS   = OUT_WIDTH - 1;
  localparam int NUM_POINTS  = 4;
  localparam int NUM_LENGTHS = 6;
  localparam int NUM_TRI     = 3;

  localparam int TRI_TOTAL  = 0;
  localparam int TRI_EDGE01 = 1;
  localparam int TRI_EDGE12 = 2;

  // segment endpoints: v0v1, v1v2, v2v0, qv0, qv1, qv2
  function automatic int pair_a(input int idx);
    case (idx)
      0: pair_a = 0;
      1: pair_a = 1;
      2: pair_a = 2;
      default: pair_a = 3;
    endcase
  endfunction

  function automatic int pair_b(input int idx);
    case (idx)
      0: pair_b = 1;
      1: pair_b = 2;
      2: pair_b = 0;
      3: pair_b = 0;
      4: pair_b = 1;
      default: pair_b = 2;
    endcase
  endfunction

  // side lengths of each triangle, as segment indexes
  function automatic int side_a(input int t);
    case (t)
      TRI_TOTAL: side_a = 0;
      TRI_EDGE01: side_a = 0;
      default: side_a = 1;
    endcase
  endfunction

  function automatic int side_b(input int t);
    case (t)
      TRI_TOTAL: side_b = 1;
      TRI_EDGE01: side_b = 3;
      default: side_b = 4;
    endcase
  endfunction

  function automatic int side_c(input int t);
    case (t)
      TRI_TOTAL: side_c = 2;
      TRI_EDGE01: side_c = 4;
      default: side_c = 5;
    endcase
  endfunction

endpackage

[rtl/bwh_length.sv]
module bwh_length #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [bwh_pkg::NUM_POINTS-1:0][2:0][COORD_WIDTH-1:0] coord,
  output logic out_valid,
  output logic [bwh_pkg::NUM_LENGTHS-1:0][COORD_WIDTH:0] len
);
  import bwh_pkg::*;

  localparam int LW = COORD_WIDTH + 1;
  localparam int MW = COORD_WIDTH + 1;
  localparam int QW = 2 * LW;
  localparam int RW = LW + 2;

  logic [NUM_POINTS-1:0][2:0][COORD_WIDTH-1:0] cr;
  logic v1, v2, v3;
  logic signed [COORD_WIDTH:0] dif [NUM_LENGTHS][3];
  logic [MW-1:0] magn [NUM_LENGTHS][3];
  logic [MW-1:0] mag [NUM_LENGTHS][3];
  logic [2*MW-1:0] sqr [NUM_LENGTHS][3];

  logic [QW-1:0] sx [NUM_LENGTHS][LW+1];
  logic [RW-1:0] sr [NUM_LENGTHS][LW+1];
  logic [LW-1:0] sq [NUM_LENGTHS][LW+1];
  logic [LW:0]   sv;

  logic [RW-1:0] rem [NUM_LENGTHS][LW];
  logic [RW-1:0] trl [NUM_LENGTHS][LW];
  logic [QW-1:0] sx_next [NUM_LENGTHS][LW];
  logic [RW-1:0] sr_next [NUM_LENGTHS][LW];
  logic [LW-1:0] sq_next [NUM_LENGTHS][LW];

  always_comb begin
    for (int l = 0; l < NUM_LENGTHS; l++) begin
      for (int a = 0; a < 3; a++) begin
        dif[l][a] = $signed({cr[pair_a(l)][a][COORD_WIDTH-1], cr[pair_a(l)][a]})
                  - $signed({cr[pair_b(l)][a][COORD_WIDTH-1], cr[pair_b(l)][a]});
        magn[l][a] = dif[l][a][COORD_WIDTH] ? MW'(-dif[l][a]) : MW'(dif[l][a]);
      end
    end
  end

  // one root bit per stage
  always_comb begin
    for (int l = 0; l < NUM_LENGTHS; l++) begin
      for (int s = 0; s < LW; s++) begin
        rem[l][s] = {sr[l][s][LW-1:0], sx[l][s][QW-1 -: 2]};
        trl[l][s] = {sq[l][s], 2'b01};
        sx_next[l][s] = sx[l][s] << 2;
        if (rem[l][s] >= trl[l][s]) begin
          sr_next[l][s] = rem[l][s] - trl[l][s];
          sq_next[l][s] = {sq[l][s][LW-2:0], 1'b1};
        end else begin
          sr_next[l][s] = rem[l][s];
          sq_next[l][s] = {sq[l][s][LW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      sv <= '0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      sv <= {sv[LW-1:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    cr <= coord;
    for (int l = 0; l < NUM_LENGTHS; l++) begin
      for (int a = 0; a < 3; a++) begin
        mag[l][a] <= magn[l][a];
        sqr[l][a] <= mag[l][a] * mag[l][a];
      end
      sx[l][0] <= QW'(sqr[l][0]) + QW'(sqr[l][1]) + QW'(sqr[l][2]);
      sr[l][0] <= '0;
      sq[l][0] <= '0;
      for (int s = 0; s < LW; s++) begin
        sx[l][s+1] <= sx_next[l][s];
        sr[l][s+1] <= sr_next[l][s];
        sq[l][s+1] <= sq_next[l][s];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LENGTHS; l++) begin
      len[l] = sq[l][LW];
    end
  end

  assign out_valid = sv[LW];

endmodule

[rtl/bwh_heron.sv]
module bwh_heron #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [bwh_pkg::NUM_LENGTHS-1:0][COORD_WIDTH:0] len,
  output logic out_valid,
  output logic [bwh_pkg::NUM_TRI-1:0][4*COORD_WIDTH+8:0] area_sq
);
  import bwh_pkg::*;

  localparam int LW = COORD_WIDTH + 1;
  localparam int SW = LW + 2;
  localparam int H  = LW + 2;
  localparam int XW = 2 * LW + 3;
  localparam int YW = 2 * LW + 2;
  localparam int MDW = 2 * LW + 4;
  localparam int PW = 4 * LW + 5;

  logic signed [SW-1:0] f1c [NUM_TRI];
  logic signed [SW-1:0] f2c [NUM_TRI];
  logic signed [SW-1:0] f3c [NUM_TRI];

  logic [SW-1:0] per [NUM_TRI];
  logic [LW:0]   f1 [NUM_TRI];
  logic [LW:0]   f2 [NUM_TRI];
  logic [LW:0]   f3 [NUM_TRI];
  logic [XW-1:0] xp [NUM_TRI];
  logic [YW-1:0] yp [NUM_TRI];
  logic [2*LW:0]   hh [NUM_TRI];
  logic [XW-1:0]   hl [NUM_TRI];
  logic [YW-1:0]   lh [NUM_TRI];
  logic [2*H-1:0]  ll [NUM_TRI];
  logic [2*LW:0]   hh_d [NUM_TRI];
  logic [MDW-1:0]  mid [NUM_TRI];
  logic [2*H-1:0]  ll_d [NUM_TRI];
  logic [NUM_TRI-1:0] neg_a, neg_b, neg_c, neg_d;
  logic va, vb, vc, vd, ve;

  always_comb begin
    for (int t = 0; t < NUM_TRI; t++) begin
      f1c[t] = $signed(SW'(len[side_b(t)]) + SW'(len[side_c(t)]) - SW'(len[side_a(t)]));
      f2c[t] = $signed(SW'(len[side_a(t)]) + SW'(len[side_c(t)]) - SW'(len[side_b(t)]));
      f3c[t] = $signed(SW'(len[side_a(t)]) + SW'(len[side_b(t)]) - SW'(len[side_c(t)]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < NUM_TRI; t++) begin
      per[t] <= SW'(len[side_a(t)]) + SW'(len[side_b(t)]) + SW'(len[side_c(t)]);
      f1[t] <= f1c[t][LW:0];
      f2[t] <= f2c[t][LW:0];
      f3[t] <= f3c[t][LW:0];
      neg_a[t] <= f1c[t][SW-1] | f2c[t][SW-1] | f3c[t][SW-1];

      xp[t] <= XW'(per[t]) * XW'(f1[t]);
      yp[t] <= YW'(f2[t]) * YW'(f3[t]);
      neg_b[t] <= neg_a[t];

      hh[t] <= (2*LW+1)'(xp[t][XW-1:H]) * (2*LW+1)'(yp[t][YW-1:H]);
      hl[t] <= XW'(xp[t][XW-1:H]) * XW'(yp[t][H-1:0]);
      lh[t] <= YW'(xp[t][H-1:0]) * YW'(yp[t][YW-1:H]);
      ll[t] <= (2*H)'(xp[t][H-1:0]) * (2*H)'(yp[t][H-1:0]);
      neg_c[t] <= neg_b[t];

      mid[t]  <= MDW'(hl[t]) + MDW'(lh[t]);
      hh_d[t] <= hh[t];
      ll_d[t] <= ll[t];
      neg_d[t] <= neg_c[t];

      area_sq[t] <= neg_d[t] ? '0 :
                    (PW'(hh_d[t]) << (2*H)) + (PW'(mid[t]) << H) + PW'(ll_d[t]);
    end
  end

  assign out_valid = ve;

endmodule

[rtl/bwh_ratio.sv]
module bwh_ratio #(
  parameter int COORD_WIDTH          = 24,
  parameter int WEIGHT_FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [bwh_pkg::NUM_TRI-1:0][4*COORD_WIDTH+8:0] area_sq,
  output logic done,
  output logic signed [bwh_pkg::OUT_WIDTH-1:0] weight_edge01,
  output logic signed [bwh_pkg::OUT_WIDTH-1:0] weight_edge12,
  output logic signed [bwh_pkg::OUT_WIDTH-1:0] weight_rest,
  output logic degenerate
);
  import bwh_pkg::*;

  localparam int PW = 4 * COORD_WIDTH + 9;
  localparam int RB = ROOT_BITS;
  localparam int WF = WEIGHT_FRACTION_BITS;
  localparam int NW = PW + 2 * WF;
  localparam int AW = PW + ((2 * RB > 2 * WF) ? 2 * RB : 2 * WF) + 2;
  localparam int RW = ((WF > OUT_WIDTH) ? WF : OUT_WIDTH) + 3;
  localparam logic signed [RW-1:0] REST_MAX = RW'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
  localparam logic signed [RW-1:0] REST_MIN = ~REST_MAX;

  logic [PW-1:0] pt [RB+1];
  logic [NW-1:0] num [2][RB+1];
  logic [AW-1:0] ta [2][RB+1];
  logic [AW-1:0] ua [2][RB+1];
  logic [RB-1:0] wr [2][RB+1];
  logic [RB:0]   sv;

  logic [AW-1:0] cand [2][RB];
  logic [AW-1:0] ta_next [2][RB];
  logic [AW-1:0] ua_next [2][RB];
  logic [RB-1:0] wr_next [2][RB];

  logic                 degen;
  logic signed [RW-1:0] restv;
  logic signed [RW-1:0] rest_sat;

  // candidate r|2^k: (r+2^k)^2*pt = r^2*pt + (r*pt)<<(k+1) + pt<<2k
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int s = 0; s < RB; s++) begin
        cand[j][s] = ta[j][s] + (ua[j][s] << (RB - s))
                   + (AW'(pt[s]) << (2 * (RB - 1 - s)));
        if (cand[j][s] <= AW'(num[j][s])) begin
          ta_next[j][s] = cand[j][s];
          ua_next[j][s] = ua[j][s] + (AW'(pt[s]) << (RB - 1 - s));
          wr_next[j][s] = wr[j][s] | (RB'(1) << (RB - 1 - s));
        end else begin
          ta_next[j][s] = ta[j][s];
          ua_next[j][s] = ua[j][s];
          wr_next[j][s] = wr[j][s];
        end
      end
    end
  end

  always_comb begin
    degen = (pt[RB] == '0);
    restv = (RW'(1) << WF) - RW'(wr[0][RB]) - RW'(wr[1][RB]);
    if (restv > REST_MAX) begin
      rest_sat = REST_MAX;
    end else if (restv < REST_MIN) begin
      rest_sat = REST_MIN;
    end else begin
      rest_sat = restv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv   <= '0;
      done <= 1'b0;
    end else begin
      sv   <= {sv[RB-1:0], in_valid};
      done <= sv[RB];
    end
  end

  always_ff @(posedge clk) begin
    pt[0]     <= area_sq[TRI_TOTAL];
    num[0][0] <= NW'(area_sq[TRI_EDGE01]) << (2 * WF);
    num[1][0] <= NW'(area_sq[TRI_EDGE12]) << (2 * WF);
    for (int j = 0; j < 2; j++) begin
      ta[j][0] <= '0;
      ua[j][0] <= '0;
      wr[j][0] <= '0;
    end
    for (int s = 0; s < RB; s++) begin
      pt[s+1] <= pt[s];
      for (int j = 0; j < 2; j++) begin
        num[j][s+1] <= num[j][s];
        ta[j][s+1]  <= ta_next[j][s];
        ua[j][s+1]  <= ua_next[j][s];
        wr[j][s+1]  <= wr_next[j][s];
      end
    end
    degenerate    <= degen;
    weight_edge01 <= degen ? '0 : $signed({1'b0, wr[0][RB]});
    weight_edge12 <= degen ? '0 : $signed({1'b0, wr[1][RB]});
    weight_rest   <= degen ? '0 : rest_sat[OUT_WIDTH-1:0];
  end

endmodule

[rtl/barycentric_weights_heron.sv]
// Barycentric-style weights of a query point against a 3D triangle, areas by
// Heron's formula from six square-rooted lengths.
// Input channel: drive the twelve coordinates and raise start for one cycle;
// the beat is taken at the rising edge where start is high and busy is low.
// busy never rises, so a new beat can be taken in every cycle.
// Output channel: done is high for exactly one cycle with weight_edge01,
// weight_edge12, weight_rest and degenerate valid in that cycle; the receiver
// cannot stall and must take the beat then.
// Pipeline: difference, square and sum registers, then the bit-serial square root
// (one root bit per stage), the Heron product registers, and the ratio root
// search (one weight bit per stage) plus the output register.
// Throughput: one beat per cycle; beats leave in the order they entered.
// Reset clears all valid bits; beats in flight are dropped and done stays low.
module barycentric_weights_heron #(
  parameter int COORD_WIDTH          = 24,
  parameter int WEIGHT_FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [COORD_WIDTH-1:0] first_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] first_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] first_vertex_z,
  input  logic signed [COORD_WIDTH-1:0] second_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] second_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] second_vertex_z,
  input  logic signed [COORD_WIDTH-1:0] third_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] third_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] third_vertex_z,
  input  logic signed [COORD_WIDTH-1:0] query_x,
  input  logic signed [COORD_WIDTH-1:0] query_y,
  input  logic signed [COORD_WIDTH-1:0] query_z,
  output logic done,
  output logic signed [bwh_pkg::OUT_WIDTH-1:0] weight_edge01,
  output logic signed [bwh_pkg::OUT_WIDTH-1:0] weight_edge12,
  output logic signed [bwh_pkg::OUT_WIDTH-1:0] weight_rest,
  output logic degenerate
);
  import bwh_pkg::*;

  logic [NUM_POINTS-1:0][2:0][COORD_WIDTH-1:0] coord;
  logic [NUM_LENGTHS-1:0][COORD_WIDTH:0]      len;
  logic [NUM_TRI-1:0][4*COORD_WIDTH+8:0]      area_sq;
  logic len_valid, area_valid;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    coord[0][0] = first_vertex_x;
    coord[0][1] = first_vertex_y;
    coord[0][2] = first_vertex_z;
    coord[1][0] = second_vertex_x;
    coord[1][1] = second_vertex_y;
    coord[1][2] = second_vertex_z;
    coord[2][0] = third_vertex_x;
    coord[2][1] = third_vertex_y;
    coord[2][2] = third_vertex_z;
    coord[3][0] = query_x;
    coord[3][1] = query_y;
    coord[3][2] = query_z;
  end

  bwh_length #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_length (
    .clk(clk),
    .rst(rst),
    .in_valid(accept),
    .coord(coord),
    .out_valid(len_valid),
    .len(len)
  );

  bwh_heron #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_heron (
    .clk(clk),
    .rst(rst),
    .in_valid(len_valid),
    .len(len),
    .out_valid(area_valid),
    .area_sq(area_sq)
  );

  bwh_ratio #(
    .COORD_WIDTH(COORD_WIDTH),
    .WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)
  ) u_ratio (
    .clk(clk),
    .rst(rst),
    .in_valid(area_valid),
    .area_sq(area_sq),
    .done(done),
    .weight_edge01(weight_edge01),
    .weight_edge12(weight_edge12),
    .weight_rest(weight_rest),
    .degenerate(degenerate)
  );

endmodule

[test/barycentric_weights_heron_tb.sv]
module barycentric_weights_heron_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 24;
  localparam int WFB = 16;
  localparam int OW = bwh_pkg::OUT_WIDTH;
  localparam int STALL_LIMIT = 5000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [OW-1:0] weight_t;
  typedef bit [255:0] wide_t;

  typedef struct packed {
    weight_t w01;
    weight_t w12;
    weight_t rest;
    logic degen;
  } weights_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  coord_t crd [12];
  logic done;
  weight_t weight_edge01, weight_edge12, weight_rest;
  logic degenerate;

  weights_t pending_weights [$];
  int errors = 0;
  int stall_cycles = 0;

  initial foreach (crd[i]) crd[i] = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  barycentric_weights_heron u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_vertex_x(crd[0]), .first_vertex_y(crd[1]), .first_vertex_z(crd[2]),
    .second_vertex_x(crd[3]), .second_vertex_y(crd[4]), .second_vertex_z(crd[5]),
    .third_vertex_x(crd[6]), .third_vertex_y(crd[7]), .third_vertex_z(crd[8]),
    .query_x(crd[9]), .query_y(crd[10]), .query_z(crd[11]),
    .done(done), .weight_edge01(weight_edge01), .weight_edge12(weight_edge12),
    .weight_rest(weight_rest), .degenerate(degenerate)
  );

  function automatic wide_t seg_length(input longint p [3], input longint q [3]);
    wide_t sum, r, c;
    longint d;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = p[i] - q[i];
      if (d < 0) d = -d;
      sum += wide_t'(d) * wide_t'(d);
    end
    r = '0;
    for (int k = 36; k > 0; k--) begin
      c = r | (wide_t'(1) << (k - 1));
      if (c * c <= sum) r = c;
    end
    return r;
  endfunction

  function automatic wide_t heron_sq(input wide_t a, input wide_t b, input wide_t c);
    longint sa, sb, sc, f1, f2, f3;
    sa = longint'(a);
    sb = longint'(b);
    sc = longint'(c);
    f1 = sb + sc - sa;
    f2 = sa + sc - sb;
    f3 = sa + sb - sc;
    if (f1 < 0 || f2 < 0 || f3 < 0) return '0;
    return wide_t'(sa + sb + sc) * wide_t'(f1) * wide_t'(f2) * wide_t'(f3);
  endfunction

  function automatic wide_t area_ratio(input wide_t psub, input wide_t ptot);
    wide_t r, c, lim;
    lim = psub << (2 * WFB);
    r = '0;
    for (int k = OW - 1; k > 0; k--) begin
      c = r | (wide_t'(1) << (k - 1));
      if (c * c * ptot <= lim) r = c;
    end
    return r;
  endfunction

  function automatic weights_t predict_weights(input coord_t c [12]);
    longint v [4][3];
    wide_t l01, l12, l20, lp0, lp1, lp2, ptot, p01, p12, w01, w12;
    longint rest;
    weights_t res;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++)
        v[i][j] = longint'(c[i*3+j]);
    l01 = seg_length(v[0], v[1]);
    l12 = seg_length(v[1], v[2]);
    l20 = seg_length(v[2], v[0]);
    lp0 = seg_length(v[3], v[0]);
    lp1 = seg_length(v[3], v[1]);
    lp2 = seg_length(v[3], v[2]);
    ptot = heron_sq(l01, l12, l20);
    p01 = heron_sq(l01, lp0, lp1);
    p12 = heron_sq(l12, lp1, lp2);
    res = '0;
    if (ptot == 0) begin
      res.degen = 1'b1;
      return res;
    end
    w01 = area_ratio(p01, ptot);
    w12 = area_ratio(p12, ptot);
    rest = (longint'(1) << WFB) - longint'(w01) - longint'(w12);
    if (rest > (longint'(1) << (OW - 1)) - 1) rest = (longint'(1) << (OW - 1)) - 1;
    if (rest < -(longint'(1) << (OW - 1))) rest = -(longint'(1) << (OW - 1));
    res.w01 = w01[OW-1:0];
    res.w12 = w12[OW-1:0];
    res.rest = rest[OW-1:0];
    return res;
  endfunction

  // start stays high after the beat; the caller lowers it through idle
  task automatic send_beat(input coord_t c [12]);
    start <= 1'b1;
    foreach (crd[i]) crd[i] <= c[i];
    do @(posedge clk); while (busy);
    pending_weights.insert(pending_weights.size(), predict_weights(c));
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(input int span);
    if (span >= CW) return coord_t'($urandom);
    return coord_t'($urandom_range(0, (1 << span) - 1)) - coord_t'(1 << (span - 1));
  endfunction

  task automatic send_tri(input longint a [12]);
    coord_t c [12];
    foreach (c[i]) c[i] = coord_t'(a[i]);
    send_beat(c);
    idle_gap();
  endtask

  task automatic test_degenerate();
    send_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_tri('{100, 200, 300, 100, 200, 300, 100, 200, 300, 7, 8, 9});
    send_tri('{0, 0, 0, 256, 0, 0, 512, 0, 0, 10, 20, 30});
    // truncated lengths that meet or break the triangle inequality
    send_tri('{0, 0, 0, 2, 2, 0, 5, 5, 0, 1, 1, 1});
    send_tri('{0, 0, 0, 3, 1, 0, 6, 2, 0, -4, 9, 2});
  endtask

  task automatic test_extremes();
    longint mx, mn;
    mx = (longint'(1) << (CW - 1)) - 1;
    mn = -(longint'(1) << (CW - 1));
    send_tri('{mn, mn, mn, mx, mn, mn, mn, mx, mn, mx, mx, mx});
    send_tri('{mx, mx, mx, mn, mx, mx, mx, mn, mx, mn, mn, mn});
    send_tri('{mn, 0, 0, mx, 0, 0, 0, mx, 0, 0, 0, mx});
    send_tri('{mn, mn, 0, mx, mn, 0, mn, mx, 0, 0, 0, 0});
    send_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0});
    send_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0});
    send_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0, 85, 85, 0});
    send_tri('{-1, -1, -1, 1000, 0, 0, 0, 1000, 0, 300, 300, 0});
  endtask

  task automatic test_saturation();
    longint mx, mn;
    mx = (longint'(1) << (CW - 1)) - 1;
    mn = -(longint'(1) << (CW - 1));
    send_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0, mx, mx, mx});
    send_tri('{0, 0, 0, 16, 0, 0, 0, 16, 0, mn, 5, 0});
    send_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, mx, 0});
    send_tri('{10, 10, 10, 20, 10, 10, 10, 20, 10, 0, 0, mn});
    send_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0, 5000, -5000, 300});
  endtask

  task automatic test_random(input int count);
    coord_t c [12];
    int span, kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      span = (kind < 3) ? CW : $urandom_range(6, 20);
      for (int i = 0; i < 9; i++) c[i] = rand_coord(span);
      if (kind == 9) begin
        for (int j = 0; j < 3; j++) c[6+j] = c[3+j] + (c[3+j] - c[j]);
      end
      if (kind >= 4 && kind < 8) begin
        for (int j = 0; j < 3; j++)
          c[9+j] = coord_t'((longint'(c[j]) + longint'(c[3+j]) + longint'(c[6+j])) / 3)
                   + rand_coord(span > 8 ? span - 2 : 6);
      end else begin
        for (int j = 0; j < 3; j++) c[9+j] = rand_coord(span);
      end
      send_beat(c);
      idle_gap();
    end
  endtask

  always @(posedge clk) begin
    weights_t exp_w;
    if (!rst && done) begin
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result beat w01=%0d w12=%0d rest=%0d degen=%0b",
                 $time, weight_edge01, weight_edge12, weight_rest, degenerate);
        errors++;
      end else begin
        exp_w = pending_weights.pop_front();
        if (weight_edge01 !== exp_w.w01) begin
          $display("%0t: weight_edge01 expected %0d actual %0d", $time, exp_w.w01,
                   weight_edge01);
          errors++;
        end
        if (weight_edge12 !== exp_w.w12) begin
          $display("%0t: weight_edge12 expected %0d actual %0d", $time, exp_w.w12,
                   weight_edge12);
          errors++;
        end
        if (weight_rest !== exp_w.rest) begin
          $display("%0t: weight_rest expected %0d actual %0d", $time, exp_w.rest,
                   weight_rest);
          errors++;
        end
        if (degenerate !== exp_w.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, exp_w.degen,
                   degenerate);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_degenerate();
    test_extremes();
    drain_results();
    test_saturation();
    test_random(430);
    drain_results();
    repeat (CW + 40) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
